@@ hdl/dcbf_pkg.sv @@
`timescale 1ns / 1ps

package dcbf_pkg;

    localparam int LEVEL_FRAC_BITS_DEF = 16;

    localparam int ELAPSED_W = 10;
    localparam int DUR_W     = 16;
    localparam int LEVEL_W   = 6;
    localparam int PERIOD_W  = 16;
    localparam int TIME_W    = 21;

    localparam logic [PERIOD_W-1:0]      FRAME_PERIOD_RST = 16'd16667;
    localparam logic [TIME_W-1:0]        FRAME_SCALE      = 21'd1000;
    localparam logic [TIME_W-1:0]        TIME_MAX         = '1;
    localparam logic signed [LEVEL_W-1:0] LEVEL_MIN       = -6'sd16;
    localparam logic signed [LEVEL_W-1:0] LEVEL_MAX       = 6'sd16;

    // floor(x / 1000) for x below 2^32: ((x >> 3) * FRAME_RECIP) >> FRAME_RECIP_SHIFT
    localparam int                       FRAME_PRE_SHIFT   = 3;
    localparam int                       FRAME_RECIP_W     = 29;
    localparam int                       FRAME_RECIP_SHIFT = 35;
    localparam logic [FRAME_RECIP_W-1:0] FRAME_RECIP       = 29'd274877907;

    // command queue, depth kept at a power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        REQ_TICK,
        REQ_SET,
        REQ_APPLY,
        REQ_ARM
    } req_t;

    typedef enum logic [1:0] {
        LOCK_NONE,
        LOCK_SET,
        LOCK_CLEAR
    } lock_t;

    typedef struct packed {
        req_t                        req;
        logic [ELAPSED_W-1:0]        elapsed;
        logic [1:0]                  mask;
        logic signed [LEVEL_W-1:0]   target;
        logic [DUR_W-1:0]            duration;
        logic                        in_ms;
        logic                        dur_zero;
        logic                        need_conv;
        lock_t                       lock;
        logic                        accepted;
    } cmd_t;

endpackage

@@ hdl/dual_channel_brightness_fader_core.sv @@
// Channel   Ports        Handshake      Carries
// s_        s_*          valid/ready    request: tick, set fade, apply, arm
// m_        m_*          valid/ready    write levels and fade states
// cfg_      cfg_wr_*     write enable   frame period, thousandths of ms
//
// A set with a frame duration first converts it (the /1000 is a reciprocal multiply).
// A tick runs the divider for each channel that divides; an idle channel or one whose
// time runs out skips it. N is the divider width, max(LEVEL_FRAC_BITS + 16, 32).
// A two-entry command queue lets the input side run ahead of the back end.
// Reset is synchronous, active low; levels clear to zero, apply is armed.
// A stalled m_ready holds the result register and the back end waits on it.
`timescale 1ns / 1ps

module dual_channel_brightness_fader_core #(
    parameter int LEVEL_FRAC_BITS = dcbf_pkg::LEVEL_FRAC_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [dcbf_pkg::PERIOD_W-1:0]         cfg_wr_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [1:0]                            s_req_type,
    input  logic [dcbf_pkg::ELAPSED_W-1:0]        s_elapsed,
    input  logic [1:0]                            s_channel_mask,
    input  logic signed [dcbf_pkg::LEVEL_W-1:0]   s_target_level,
    input  logic [dcbf_pkg::DUR_W-1:0]            s_duration,
    input  logic                                  s_duration_in_ms,
    input  logic [1:0]                            s_lock_action,
    input  logic                                  s_accepted,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_main_write_valid,
    output logic signed [dcbf_pkg::LEVEL_W-1:0]   m_main_write_level,
    output logic                                  m_sub_write_valid,
    output logic signed [dcbf_pkg::LEVEL_W-1:0]   m_sub_write_level,
    output logic [1:0]                            m_main_fade_state,
    output logic [1:0]                            m_sub_fade_state,
    output logic                                  m_any_fading
);
    import dcbf_pkg::*;

    logic push_valid;
    logic push_ready;
    cmd_t push_data;
    logic pop_valid;
    logic pop;
    cmd_t pop_data;

    dcbf_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_type       (s_req_type),
        .s_elapsed        (s_elapsed),
        .s_channel_mask   (s_channel_mask),
        .s_target_level   (s_target_level),
        .s_duration       (s_duration),
        .s_duration_in_ms (s_duration_in_ms),
        .s_lock_action    (s_lock_action),
        .s_accepted       (s_accepted),
        .push_valid       (push_valid),
        .push_ready       (push_ready),
        .push_data        (push_data)
    );

    dcbf_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_data   (pop_data)
    );

    dcbf_back #(
        .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
    ) u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .q_valid            (pop_valid),
        .q_pop              (pop),
        .q_data             (pop_data),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_main_write_valid (m_main_write_valid),
        .m_main_write_level (m_main_write_level),
        .m_sub_write_valid  (m_sub_write_valid),
        .m_sub_write_level  (m_sub_write_level),
        .m_main_fade_state  (m_main_fade_state),
        .m_sub_fade_state   (m_sub_fade_state),
        .m_any_fading       (m_any_fading)
    );

endmodule

@@ hdl/dcbf_front.sv @@
`timescale 1ns / 1ps

module dcbf_front (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [1:0]                            s_req_type,
    input  logic [dcbf_pkg::ELAPSED_W-1:0]        s_elapsed,
    input  logic [1:0]                            s_channel_mask,
    input  logic signed [dcbf_pkg::LEVEL_W-1:0]   s_target_level,
    input  logic [dcbf_pkg::DUR_W-1:0]            s_duration,
    input  logic                                  s_duration_in_ms,
    input  logic [1:0]                            s_lock_action,
    input  logic                                  s_accepted,
    output logic                                  push_valid,
    input  logic                                  push_ready,
    output dcbf_pkg::cmd_t                        push_data
);
    import dcbf_pkg::*;

    cmd_t cmd_dec;
    cmd_t hold_reg;
    cmd_t hold_next;
    logic hold_valid_reg;
    logic hold_valid_next;
    logic accept;

    always_comb begin
        cmd_dec.req      = req_t'(s_req_type);
        cmd_dec.elapsed  = s_elapsed;
        cmd_dec.mask     = s_channel_mask;
        if (s_target_level < LEVEL_MIN) begin
            cmd_dec.target = LEVEL_MIN;
        end else if (s_target_level > LEVEL_MAX) begin
            cmd_dec.target = LEVEL_MAX;
        end else begin
            cmd_dec.target = s_target_level;
        end
        cmd_dec.duration  = s_duration;
        cmd_dec.in_ms     = s_duration_in_ms;
        cmd_dec.dur_zero  = (s_duration == '0);
        cmd_dec.need_conv = !s_duration_in_ms && (s_duration != '0);
        case (lock_t'(s_lock_action))
            LOCK_SET: begin
                cmd_dec.lock = LOCK_SET;
            end
            LOCK_CLEAR: begin
                cmd_dec.lock = LOCK_CLEAR;
            end
            default: begin
                cmd_dec.lock = LOCK_NONE;
            end
        endcase
        cmd_dec.accepted = s_accepted;
    end

    assign s_ready    = !hold_valid_reg || push_ready;
    assign accept     = s_valid && s_ready;
    assign push_valid = hold_valid_reg;
    assign push_data  = hold_reg;

    always_comb begin
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        if (hold_valid_reg && push_ready) begin
            hold_valid_next = 1'b0;
        end
        if (accept) begin
            hold_next       = cmd_dec;
            hold_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
        hold_reg <= hold_next;
    end

endmodule

@@ hdl/dcbf_fifo.sv @@
`timescale 1ns / 1ps

module dcbf_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    output logic            push_ready,
    input  dcbf_pkg::cmd_t  push_data,
    output logic            pop_valid,
    input  logic            pop,
    output dcbf_pkg::cmd_t  pop_data
);
    import dcbf_pkg::*;

    cmd_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (count_reg != (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + (QUEUE_AW + 1)'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - (QUEUE_AW + 1)'(1);
            end
        end
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ hdl/dcbf_div.sv @@
`timescale 1ns / 1ps

module dcbf_div #(
    parameter int NW = 32,
    parameter int DW = 21
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [NW-1:0] quotient
);
    localparam int CW = $clog2(NW + 1);

    logic [DW-1:0] rem_reg;
    logic [DW-1:0] rem_next;
    logic [NW-1:0] quo_reg;
    logic [NW-1:0] quo_next;
    logic [DW-1:0] dvs_reg;
    logic [DW-1:0] dvs_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          busy_reg;
    logic          busy_next;
    logic          done_reg;
    logic          done_next;
    logic [DW:0]   shifted;
    logic [DW:0]   trial;
    logic          fits;

    // restoring division, one quotient bit per cycle
    assign shifted = {rem_reg, quo_reg[NW-1]};
    assign fits    = (shifted >= {1'b0, dvs_reg});
    assign trial   = shifted - {1'b0, dvs_reg};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? trial[DW-1:0] : shifted[DW-1:0];
            quo_next = {quo_reg[NW-2:0], fits};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ hdl/dcbf_back.sv @@
`timescale 1ns / 1ps

module dcbf_back #(
    parameter int LEVEL_FRAC_BITS = dcbf_pkg::LEVEL_FRAC_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [dcbf_pkg::PERIOD_W-1:0]         cfg_wr_data,
    input  logic                                  q_valid,
    output logic                                  q_pop,
    input  dcbf_pkg::cmd_t                        q_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_main_write_valid,
    output logic signed [dcbf_pkg::LEVEL_W-1:0]   m_main_write_level,
    output logic                                  m_sub_write_valid,
    output logic signed [dcbf_pkg::LEVEL_W-1:0]   m_sub_write_level,
    output logic [1:0]                            m_main_fade_state,
    output logic [1:0]                            m_sub_fade_state,
    output logic                                  m_any_fading
);
    import dcbf_pkg::*;

    localparam int LW     = LEVEL_FRAC_BITS + LEVEL_W;
    localparam int DFW    = LW + 1;
    localparam int MW     = LW;
    localparam int PW     = MW + ELAPSED_W;
    localparam int CONV_W = PERIOD_W + DUR_W;
    localparam int NW     = (PW > CONV_W) ? PW : CONV_W;
    localparam int MBW    = (MW > PERIOD_W) ? MW : PERIOD_W;
    localparam int FW     = MBW + DUR_W;
    localparam int CIW    = CONV_W - FRAME_PRE_SHIFT;
    localparam int CPW    = CIW + FRAME_RECIP_W;
    localparam int CQW    = CPW - FRAME_RECIP_SHIFT;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_CONV,
        ST_TICK,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_TICK_UPD,
        ST_SET,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        FADE_IDLE,
        FADE_TO_ZERO,
        FADE_TO_NEG,
        FADE_TO_POS
    } fade_t;

    function automatic logic [1:0] fade_code(input logic [TIME_W-1:0] tl,
                                             input logic signed [LEVEL_W-1:0] tg);
        fade_t f;
        if (tl == '0) begin
            f = FADE_IDLE;
        end else if (tg < 0) begin
            f = FADE_TO_NEG;
        end else if (tg > 0) begin
            f = FADE_TO_POS;
        end else begin
            f = FADE_TO_ZERO;
        end
        return f;
    endfunction

    // integer part, truncated toward zero
    function automatic logic signed [LEVEL_W-1:0] level_int(input logic signed [LW-1:0] lv);
        logic [LEVEL_W-1:0] ip;
        ip = lv[LW-1:LEVEL_FRAC_BITS];
        if (lv[LW-1] && (lv[LEVEL_FRAC_BITS-1:0] != '0)) begin
            ip = ip + LEVEL_W'(1);
        end
        return $signed(ip);
    endfunction

    function automatic logic signed [LW-1:0] to_fixed(input logic signed [LEVEL_W-1:0] t);
        return $signed({t, {LEVEL_FRAC_BITS{1'b0}}});
    endfunction

    state_t                    state_reg, state_next;
    cmd_t                      cmd_reg, cmd_next;
    logic                      ch_reg, ch_next;
    logic [NW-1:0]             prod_reg, prod_next;
    logic [TIME_W-1:0]         dvs_reg, dvs_next;
    logic                      neg_reg, neg_next;
    logic [CQW-1:0]            conv_reg, conv_next;
    logic [PERIOD_W-1:0]       period_reg;

    logic signed [LW-1:0]      level_reg  [2];
    logic signed [LW-1:0]      level_next [2];
    logic signed [LEVEL_W-1:0] target_reg  [2];
    logic signed [LEVEL_W-1:0] target_next [2];
    logic [TIME_W-1:0]         tleft_reg  [2];
    logic [TIME_W-1:0]         tleft_next [2];
    logic [1:0]                dirty_reg, dirty_next;
    logic [1:0]                locked_reg, locked_next;
    logic                      armed_reg, armed_next;

    logic                      m_valid_reg, m_valid_next;
    logic                      m_main_wv_reg, m_main_wv_next;
    logic signed [LEVEL_W-1:0] m_main_wl_reg, m_main_wl_next;
    logic                      m_sub_wv_reg, m_sub_wv_next;
    logic signed [LEVEL_W-1:0] m_sub_wl_reg, m_sub_wl_next;
    logic [1:0]                m_main_fs_reg, m_main_fs_next;
    logic [1:0]                m_sub_fs_reg, m_sub_fs_next;
    logic                      m_any_reg, m_any_next;

    logic                      div_start;
    logic                      div_done;
    logic [NW-1:0]             quo;

    logic signed [LW-1:0]      cur_tfix;
    logic signed [DFW-1:0]     cur_diff;
    logic [DFW-1:0]            cur_mag_full;
    logic [MW-1:0]             cur_mag;
    logic [TIME_W-1:0]         elapsed_ext;
    logic [DUR_W-1:0]          mul_a;
    logic [MBW-1:0]            mul_b;
    logic [FW-1:0]             mul_p;
    logic [CPW-1:0]            conv_p;
    logic signed [LW-1:0]      q_step;
    logic                      set_jump;
    logic [TIME_W-1:0]         set_time;

    dcbf_div #(
        .NW (NW),
        .DW (TIME_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (dvs_reg),
        .done     (div_done),
        .quotient (quo)
    );

    assign cur_tfix     = to_fixed(target_reg[ch_reg]);
    assign cur_diff     = $signed({cur_tfix[LW-1], cur_tfix})
                        - $signed({level_reg[ch_reg][LW-1], level_reg[ch_reg]});
    assign cur_mag_full = cur_diff[DFW-1] ? (-cur_diff) : cur_diff;
    assign cur_mag      = cur_mag_full[MW-1:0];
    assign elapsed_ext  = {{(TIME_W - ELAPSED_W){1'b0}}, cmd_reg.elapsed};

    always_comb begin
        if (state_reg == ST_TICK) begin
            mul_a = {{(DUR_W - ELAPSED_W){1'b0}}, cmd_reg.elapsed};
            mul_b = MBW'(cur_mag);
        end else begin
            mul_a = cmd_reg.duration;
            mul_b = MBW'(period_reg);
        end
    end

    assign mul_p  = mul_a * mul_b;
    // frame count times period, divided by 1000
    assign conv_p = CPW'(prod_reg[CONV_W-1:FRAME_PRE_SHIFT]) * CPW'(FRAME_RECIP);
    // the step is below the distance, so it fits without the top bit
    assign q_step = $signed({1'b0, quo[MW-2:0]});

    assign set_jump = cmd_reg.dur_zero || (cmd_reg.need_conv && (conv_reg == '0));
    always_comb begin
        if (cmd_reg.in_ms) begin
            set_time = {{(TIME_W - DUR_W){1'b0}}, cmd_reg.duration};
        end else if (conv_reg > CQW'(TIME_MAX)) begin
            set_time = TIME_MAX;
        end else begin
            set_time = conv_reg[TIME_W-1:0];
        end
    end

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        ch_next        = ch_reg;
        prod_next      = prod_reg;
        dvs_next       = dvs_reg;
        neg_next       = neg_reg;
        conv_next      = conv_reg;
        level_next     = level_reg;
        target_next    = target_reg;
        tleft_next     = tleft_reg;
        dirty_next     = dirty_reg;
        locked_next    = locked_reg;
        armed_next     = armed_reg;
        m_valid_next   = m_valid_reg;
        m_main_wv_next = m_main_wv_reg;
        m_main_wl_next = m_main_wl_reg;
        m_sub_wv_next  = m_sub_wv_reg;
        m_sub_wl_next  = m_sub_wl_reg;
        m_main_fs_next = m_main_fs_reg;
        m_sub_fs_next  = m_sub_fs_reg;
        m_any_next     = m_any_reg;
        q_pop          = 1'b0;
        div_start      = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    cmd_next   = q_data;
                    ch_next    = 1'b0;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (cmd_reg.req)
                    REQ_TICK: begin
                        state_next = ST_TICK;
                    end
                    REQ_SET: begin
                        if (cmd_reg.need_conv) begin
                            prod_next  = mul_p[NW-1:0];
                            state_next = ST_CONV;
                        end else begin
                            state_next = ST_SET;
                        end
                    end
                    default: begin
                        state_next = ST_OUT;
                    end
                endcase
            end
            ST_CONV: begin
                conv_next  = conv_p[CPW-1:FRAME_RECIP_SHIFT];
                state_next = ST_SET;
            end
            ST_TICK: begin
                if (tleft_reg[ch_reg] == '0) begin
                    ch_next    = 1'b1;
                    state_next = ch_reg ? ST_OUT : ST_TICK;
                end else if (elapsed_ext >= tleft_reg[ch_reg]) begin
                    level_next[ch_reg] = cur_tfix;
                    tleft_next[ch_reg] = '0;
                    dirty_next[ch_reg] = 1'b1;
                    ch_next            = 1'b1;
                    state_next         = ch_reg ? ST_OUT : ST_TICK;
                end else begin
                    prod_next  = mul_p[NW-1:0];
                    dvs_next   = tleft_reg[ch_reg];
                    neg_next   = cur_diff[DFW-1];
                    state_next = ST_DIV_START;
                end
            end
            ST_DIV_START: begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    state_next = ST_TICK_UPD;
                end
            end
            ST_TICK_UPD: begin
                level_next[ch_reg] = neg_reg ? (level_reg[ch_reg] - q_step)
                                             : (level_reg[ch_reg] + q_step);
                tleft_next[ch_reg] = tleft_reg[ch_reg] - elapsed_ext;
                dirty_next[ch_reg] = 1'b1;
                ch_next            = 1'b1;
                state_next         = ch_reg ? ST_OUT : ST_TICK;
            end
            ST_SET: begin
                for (int k = 0; k < 2; k++) begin
                    if (cmd_reg.mask[k]) begin
                        locked_next[k] = locked_reg[k] && (cmd_reg.lock != LOCK_CLEAR);
                        if (!locked_next[k] && cmd_reg.accepted) begin
                            target_next[k] = cmd_reg.target;
                            if (set_jump) begin
                                level_next[k] = to_fixed(cmd_reg.target);
                                tleft_next[k] = '0;
                                dirty_next[k] = 1'b1;
                            end else begin
                                tleft_next[k] = set_time;
                            end
                        end
                        if (cmd_reg.lock == LOCK_SET) begin
                            locked_next[k] = 1'b1;
                        end
                    end
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_main_wv_next = 1'b0;
                    m_main_wl_next = '0;
                    m_sub_wv_next  = 1'b0;
                    m_sub_wl_next  = '0;
                    if (cmd_reg.req == REQ_APPLY && armed_reg) begin
                        armed_next = 1'b0;
                        if (dirty_reg[0]) begin
                            m_main_wv_next = 1'b1;
                            m_main_wl_next = level_int(level_reg[0]);
                        end
                        if (dirty_reg[1]) begin
                            m_sub_wv_next = 1'b1;
                            m_sub_wl_next = level_int(level_reg[1]);
                        end
                        dirty_next = '0;
                    end
                    if (cmd_reg.req == REQ_ARM) begin
                        armed_next = 1'b1;
                    end
                    m_main_fs_next = fade_code(tleft_reg[0], target_reg[0]);
                    m_sub_fs_next  = fade_code(tleft_reg[1], target_reg[1]);
                    m_any_next     = (tleft_reg[0] != '0) || (tleft_reg[1] != '0);
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ch_reg        <= 1'b0;
            level_reg     <= '{default: '0};
            target_reg    <= '{default: '0};
            tleft_reg     <= '{default: '0};
            dirty_reg     <= '0;
            locked_reg    <= '0;
            armed_reg     <= 1'b1;
            period_reg    <= FRAME_PERIOD_RST;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            level_reg     <= level_next;
            target_reg    <= target_next;
            tleft_reg     <= tleft_next;
            dirty_reg     <= dirty_next;
            locked_reg    <= locked_next;
            armed_reg     <= armed_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_wr_en) begin
                period_reg <= cfg_wr_data;
            end
        end
        cmd_reg       <= cmd_next;
        prod_reg      <= prod_next;
        dvs_reg       <= dvs_next;
        neg_reg       <= neg_next;
        conv_reg      <= conv_next;
        m_main_wv_reg <= m_main_wv_next;
        m_main_wl_reg <= m_main_wl_next;
        m_sub_wv_reg  <= m_sub_wv_next;
        m_sub_wl_reg  <= m_sub_wl_next;
        m_main_fs_reg <= m_main_fs_next;
        m_sub_fs_reg  <= m_sub_fs_next;
        m_any_reg     <= m_any_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_main_write_valid = m_main_wv_reg;
    assign m_main_write_level = m_main_wl_reg;
    assign m_sub_write_valid  = m_sub_wv_reg;
    assign m_sub_write_level  = m_sub_wl_reg;
    assign m_main_fade_state  = m_main_fs_reg;
    assign m_sub_fade_state   = m_sub_fs_reg;
    assign m_any_fading       = m_any_reg;

endmodule

@@ verif/dual_channel_brightness_fader_core_test.sv @@
`timescale 1ns / 1ps

module dual_channel_brightness_fader_core_test;
    import dcbf_pkg::*;

    localparam int     FRAC      = LEVEL_FRAC_BITS_DEF;
    localparam longint ONE_LEVEL = 64'sd1 <<< FRAC;
    localparam longint TIME_CAP  = longint'(TIME_MAX);

    localparam logic [1:0] FADE_IDLE    = 2'd0;
    localparam logic [1:0] FADE_TO_ZERO = 2'd1;
    localparam logic [1:0] FADE_TO_NEG  = 2'd2;
    localparam logic [1:0] FADE_TO_POS  = 2'd3;
    localparam logic [1:0] LOCK_NOP     = 2'd3;   // undefined action, behaves as none

    typedef struct {
        longint level;
        int     target;
        longint time_left;
        bit     dirty;
        bit     locked;
    } fader_chan_t;

    typedef struct packed {
        logic                      main_wr_valid;
        logic signed [LEVEL_W-1:0] main_wr_level;
        logic                      sub_wr_valid;
        logic signed [LEVEL_W-1:0] sub_wr_level;
        logic [1:0]                main_state;
        logic [1:0]                sub_state;
        logic                      fading;
    } fader_result_t;

    logic                      aclk             = 1'b0;
    logic                      aresetn          = 1'b0;
    logic                      cfg_wr_en        = 1'b0;
    logic [PERIOD_W-1:0]       cfg_wr_data      = '0;
    logic                      s_valid          = 1'b0;
    logic                      s_ready;
    req_t                      s_req_type       = REQ_TICK;
    logic [ELAPSED_W-1:0]      s_elapsed        = '0;
    logic [1:0]                s_channel_mask   = '0;
    logic signed [LEVEL_W-1:0] s_target_level   = '0;
    logic [DUR_W-1:0]          s_duration       = '0;
    logic                      s_duration_in_ms = 1'b0;
    logic [1:0]                s_lock_action    = LOCK_NONE;
    logic                      s_accepted       = 1'b0;
    logic                      m_valid;
    logic                      m_ready          = 1'b0;
    logic                      m_main_write_valid;
    logic signed [LEVEL_W-1:0] m_main_write_level;
    logic                      m_sub_write_valid;
    logic signed [LEVEL_W-1:0] m_sub_write_level;
    logic [1:0]                m_main_fade_state;
    logic [1:0]                m_sub_fade_state;
    logic                      m_any_fading;

    fader_chan_t         main_fc;
    fader_chan_t         sub_fc;
    bit                  apply_armed;
    logic [PERIOD_W-1:0] frame_period;
    fader_result_t       expected_results[$];

    bit src_idle_en  = 1'b1;
    bit sink_idle_en = 1'b1;
    int mismatch_count;
    int results_checked;
    int tick_count;
    int set_count;
    int apply_count;
    int arm_count;
    int level_write_count;

    dual_channel_brightness_fader_core dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_req_type         (s_req_type),
        .s_elapsed          (s_elapsed),
        .s_channel_mask     (s_channel_mask),
        .s_target_level     (s_target_level),
        .s_duration         (s_duration),
        .s_duration_in_ms   (s_duration_in_ms),
        .s_lock_action      (s_lock_action),
        .s_accepted         (s_accepted),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_main_write_valid (m_main_write_valid),
        .m_main_write_level (m_main_write_level),
        .m_sub_write_valid  (m_sub_write_valid),
        .m_sub_write_level  (m_sub_write_level),
        .m_main_fade_state  (m_main_fade_state),
        .m_sub_fade_state   (m_sub_fade_state),
        .m_any_fading       (m_any_fading)
    );

    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready <= sink_idle_en ? ($urandom_range(99) >= 11) : 1'b1;
    end

    function automatic fader_chan_t tick_chan(fader_chan_t c, longint el);
        longint diff;
        longint mag;
        longint step;
        if (c.time_left == 0)
            return c;
        diff = c.target * ONE_LEVEL - c.level;
        mag  = (diff < 0) ? -diff : diff;
        step = (el * mag) / c.time_left;
        c.level = c.level + ((diff < 0) ? -step : step);
        if (c.time_left > el) begin
            c.time_left = c.time_left - el;
        end else begin
            c.time_left = 0;
            c.level     = c.target * ONE_LEVEL;
        end
        c.dirty = 1'b1;
        return c;
    endfunction

    function automatic fader_chan_t set_chan(fader_chan_t c, int tgt, longint dur, bit in_ms,
                                             logic [1:0] lock, bit acc);
        longint t;
        if (lock == LOCK_CLEAR)
            c.locked = 1'b0;
        if (!c.locked && acc) begin
            t = in_ms ? dur : (dur * longint'(frame_period)) / longint'(FRAME_SCALE);
            if (t > TIME_CAP)
                t = TIME_CAP;
            c.target = tgt;
            if (dur == 0 || t == 0) begin
                c.level     = tgt * ONE_LEVEL;
                c.time_left = 0;
                c.dirty     = 1'b1;
            end else begin
                c.time_left = t;
            end
        end
        if (lock == LOCK_SET)
            c.locked = 1'b1;
        return c;
    endfunction

    function automatic logic [1:0] fade_code(fader_chan_t c);
        if (c.time_left == 0)
            return FADE_IDLE;
        if (c.target < 0)
            return FADE_TO_NEG;
        if (c.target > 0)
            return FADE_TO_POS;
        return FADE_TO_ZERO;
    endfunction

    function automatic logic signed [LEVEL_W-1:0] written_level(fader_chan_t c);
        longint v;
        v = c.level / ONE_LEVEL;
        return v[LEVEL_W-1:0];
    endfunction

    function automatic fader_result_t predict_fader_step();
        fader_result_t r;
        int            tgt;
        r   = '0;
        tgt = s_target_level;
        if (tgt < int'(LEVEL_MIN))
            tgt = int'(LEVEL_MIN);
        if (tgt > int'(LEVEL_MAX))
            tgt = int'(LEVEL_MAX);
        case (s_req_type)
            REQ_TICK: begin
                tick_count++;
                main_fc = tick_chan(main_fc, s_elapsed);
                sub_fc  = tick_chan(sub_fc, s_elapsed);
            end
            REQ_SET: begin
                set_count++;
                if (s_channel_mask[0])
                    main_fc = set_chan(main_fc, tgt, s_duration, s_duration_in_ms,
                                       s_lock_action, s_accepted);
                if (s_channel_mask[1])
                    sub_fc = set_chan(sub_fc, tgt, s_duration, s_duration_in_ms,
                                      s_lock_action, s_accepted);
            end
            REQ_APPLY: begin
                apply_count++;
                if (apply_armed) begin
                    apply_armed = 1'b0;
                    if (main_fc.dirty) begin
                        r.main_wr_valid = 1'b1;
                        r.main_wr_level = written_level(main_fc);
                        level_write_count++;
                    end
                    if (sub_fc.dirty) begin
                        r.sub_wr_valid = 1'b1;
                        r.sub_wr_level = written_level(sub_fc);
                        level_write_count++;
                    end
                    main_fc.dirty = 1'b0;
                    sub_fc.dirty  = 1'b0;
                end
            end
            default: begin
                arm_count++;
                apply_armed = 1'b1;
            end
        endcase
        r.main_state = fade_code(main_fc);
        r.sub_state  = fade_code(sub_fc);
        r.fading     = (main_fc.time_left != 0) || (sub_fc.time_left != 0);
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int exp);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, exp);
    endtask

    task automatic check_fader_result();
        fader_result_t exp;
        if (expected_results.size() == 0) begin
            report_mismatch("result transaction with nothing pending", 1, 0);
            return;
        end
        exp = expected_results.pop_front();
        results_checked++;
        if (m_main_write_valid !== exp.main_wr_valid)
            report_mismatch("main_write_valid", m_main_write_valid, exp.main_wr_valid);
        if (m_main_write_level !== exp.main_wr_level)
            report_mismatch("main_write_level", m_main_write_level, exp.main_wr_level);
        if (m_sub_write_valid !== exp.sub_wr_valid)
            report_mismatch("sub_write_valid", m_sub_write_valid, exp.sub_wr_valid);
        if (m_sub_write_level !== exp.sub_wr_level)
            report_mismatch("sub_write_level", m_sub_write_level, exp.sub_wr_level);
        if (m_main_fade_state !== exp.main_state)
            report_mismatch("main_fade_state", m_main_fade_state, exp.main_state);
        if (m_sub_fade_state !== exp.sub_state)
            report_mismatch("sub_fade_state", m_sub_fade_state, exp.sub_state);
        if (m_any_fading !== exp.fading)
            report_mismatch("any_fading", m_any_fading, exp.fading);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            main_fc      = '{default: 0};
            sub_fc       = '{default: 0};
            apply_armed  = 1'b1;
            frame_period = FRAME_PERIOD_RST;
        end else begin
            if (m_valid && m_ready)
                check_fader_result();
            if (cfg_wr_en)
                frame_period = cfg_wr_data;
            if (s_valid && s_ready)
                expected_results.push_back(predict_fader_step());
        end
    end

    // called and returns on a falling edge
    task automatic send_request(req_t req, logic [ELAPSED_W-1:0] el, logic [1:0] mask,
                                logic signed [LEVEL_W-1:0] tgt, logic [DUR_W-1:0] dur,
                                bit in_ms, logic [1:0] lock, bit acc);
        while (src_idle_en && $urandom_range(99) < 11) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_req_type       <= req;
        s_elapsed        <= el;
        s_channel_mask   <= mask;
        s_target_level   <= tgt;
        s_duration       <= dur;
        s_duration_in_ms <= in_ms;
        s_lock_action    <= lock;
        s_accepted       <= acc;
        s_valid          <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic send_tick(logic [ELAPSED_W-1:0] el);
        send_request(REQ_TICK, el, 2'($urandom), LEVEL_W'($urandom), DUR_W'($urandom),
                     1'($urandom), 2'($urandom), 1'($urandom));
    endtask

    task automatic send_set(logic [1:0] mask, logic signed [LEVEL_W-1:0] tgt,
                            logic [DUR_W-1:0] dur, bit in_ms, logic [1:0] lock, bit acc);
        send_request(REQ_SET, ELAPSED_W'($urandom), mask, tgt, dur, in_ms, lock, acc);
    endtask

    task automatic send_ctrl(req_t req);
        send_request(req, ELAPSED_W'($urandom), 2'($urandom), LEVEL_W'($urandom),
                     DUR_W'($urandom), 1'($urandom), 2'($urandom), 1'($urandom));
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_frame_period(logic [PERIOD_W-1:0] val);
        wait_for_results();
        cfg_wr_data <= val;
        cfg_wr_en   <= 1'b1;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic test_apply_arming();
        send_ctrl(REQ_APPLY);
        send_ctrl(REQ_APPLY);
        send_tick(0);
        send_ctrl(REQ_ARM);
    endtask

    task automatic test_fade_and_saturation();
        send_set(2'b11, 16, 10, 1'b0, LOCK_NONE, 1'b1);
        send_tick(0);
        send_tick(100);
        send_ctrl(REQ_APPLY);
        send_set(2'b01, -32, 500, 1'b1, LOCK_NONE, 1'b1);
        send_set(2'b10, 31, 16'hFFFF, 1'b0, LOCK_NONE, 1'b1);
        send_tick(1023);
        send_ctrl(REQ_ARM);
        send_ctrl(REQ_APPLY);
        send_set(2'b11, 0, 0, 1'b1, LOCK_NONE, 1'b1);
        send_tick(1023);
    endtask

    task automatic test_lock_rules();
        send_set(2'b01, 5, 0, 1'b0, LOCK_SET, 1'b1);
        send_set(2'b01, -5, 0, 1'b0, LOCK_NONE, 1'b1);
        send_set(2'b01, 7, 0, 1'b0, LOCK_CLEAR, 1'b0);
        send_set(2'b11, -7, 20, 1'b1, LOCK_NOP, 1'b1);
        send_set(2'b00, 9, 0, 1'b0, LOCK_NONE, 1'b1);
        send_ctrl(REQ_ARM);
        send_ctrl(REQ_APPLY);
    endtask

    task automatic test_frame_period_corners();
        write_frame_period('0);
        send_set(2'b11, 3, 1, 1'b0, LOCK_NONE, 1'b1);
        write_frame_period('1);
        send_set(2'b11, -3, 16'hFFFF, 1'b0, LOCK_NONE, 1'b1);
        write_frame_period(16'd1000);
        send_set(2'b11, 12, 3, 1'b0, LOCK_NONE, 1'b1);
    endtask

    task automatic test_random_traffic(int count);
        int                        kind;
        int                        pick;
        req_t                      req;
        logic [ELAPSED_W-1:0]      el;
        logic signed [LEVEL_W-1:0] tgt;
        logic [DUR_W-1:0]          dur;
        bit                        in_ms;
        logic [1:0]                lock;
        for (int i = 0; i < count; i++) begin
            kind  = $urandom_range(99);
            req   = (kind < 40) ? REQ_TICK : (kind < 70) ? REQ_SET :
                    (kind < 85) ? REQ_APPLY : REQ_ARM;
            el    = ELAPSED_W'(($urandom_range(1) != 0) ? $urandom_range(1023)
                                                        : $urandom_range(64));
            tgt   = LEVEL_W'(($urandom_range(99) < 80) ? $urandom_range(32) - 16
                                                       : $urandom_range(63));
            in_ms = 1'($urandom_range(1));
            pick  = $urandom_range(99);
            if (pick < 8)
                dur = '0;
            else if (pick < 65)
                dur = DUR_W'(in_ms ? $urandom_range(1, 2000) : $urandom_range(1, 90));
            else
                dur = DUR_W'($urandom);
            pick  = $urandom_range(99);
            lock  = (pick < 75) ? LOCK_NONE : (pick < 86) ? LOCK_SET :
                    (pick < 97) ? LOCK_CLEAR : LOCK_NOP;
            send_request(req, el, 2'($urandom), tgt, dur, in_ms, lock,
                         $urandom_range(99) < 90);
            if ($urandom_range(99) == 0)
                wait_for_results();
        end
    endtask

    task automatic test_steady_stream();
        write_frame_period(FRAME_PERIOD_RST);
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        test_random_traffic(150);
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    task automatic test_drain_pause();
        test_random_traffic(40);
        wait_for_results();
        test_random_traffic(40);
    endtask

    task automatic test_period_sweep();
        write_frame_period('1);
        test_random_traffic(100);
        write_frame_period(16'd700);
        test_random_traffic(50);
        write_frame_period('0);
        test_random_traffic(30);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_apply_arming();
        test_fade_and_saturation();
        test_lock_rules();
        test_frame_period_corners();
        test_random_traffic(200);
        test_steady_stream();
        test_drain_pause();
        test_period_sweep();

        wait_for_results();
        repeat (100) @(negedge aclk);

        $display("Covered %0d ticks, %0d fade sets, %0d applies (%0d level writes), %0d arms",
                 tick_count, set_count, apply_count, level_write_count, arm_count);
        $display("%0d results checked over frame periods 0 to 65535, %0d mismatches",
                 results_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("TIMEOUT with %0d results outstanding", expected_results.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
